@@ src/hrp_pkg.sv @@
// Types, constants and character-class functions shared by the HTTP request head parser.
`default_nettype none

package hrp_pkg;

   // Offset limit: bytes beyond this count raise an error.
   localparam int unsigned MAX_REQUEST_BYTES = 65536;
   localparam int unsigned OffsetLimit =
      (MAX_REQUEST_BYTES < 65536) ? MAX_REQUEST_BYTES : 65536;

   // Offset counter holds the limit itself, so one bit wider than the offset fields.
   typedef logic [16:0] offset_type;
   localparam offset_type OFFSET_LIMIT = offset_type'(OffsetLimit);

   typedef enum logic [4:0] {
      ST_LINE_START = 5'd0,
      ST_METHOD     = 5'd1,
      ST_URI_START  = 5'd2,
      ST_URI        = 5'd3,
      ST_VER_START  = 5'd4,
      ST_VER_T1     = 5'd5,
      ST_VER_T2     = 5'd6,
      ST_VER_P      = 5'd7,
      ST_VER_SLASH  = 5'd8,
      ST_VER_MAJOR  = 5'd9,
      ST_VER_DOT    = 5'd10,
      ST_VER_MINOR  = 5'd11,
      ST_VER_CR     = 5'd12,
      ST_VER_LF     = 5'd13,
      ST_LINE_HEAD  = 5'd14,
      ST_KEY        = 5'd15,
      ST_SPACE      = 5'd16,
      ST_VALUE      = 5'd17,
      ST_VALUE_LF   = 5'd18,
      ST_FINAL_LF   = 5'd19,
      ST_DONE       = 5'd20,
      ST_ERR        = 5'd21
   } state_type;

   typedef enum logic [1:0] {
      STATUS_BUSY     = 2'd0,
      STATUS_COMPLETE = 2'd1,
      STATUS_ERROR    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      TOKEN_NONE   = 3'd0,
      TOKEN_METHOD = 3'd1,
      TOKEN_URI    = 3'd2,
      TOKEN_KEY    = 3'd3,
      TOKEN_VALUE  = 3'd4
   } token_kind_type;

   typedef enum logic [3:0] {
      METHOD_NONE    = 4'd0,
      METHOD_GET     = 4'd1,
      METHOD_PUT     = 4'd2,
      METHOD_POST    = 4'd3,
      METHOD_HEAD    = 4'd4,
      METHOD_TRACE   = 4'd5,
      METHOD_DELETE  = 4'd6,
      METHOD_OPTIONS = 4'd7,
      METHOD_CONNECT = 4'd8
   } method_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_request;
   } req_type;

   typedef struct packed {
      status_type     status;
      token_kind_type token_kind;
      logic [15:0]    token_start;
      logic [15:0]    token_length;
      method_type     method_code;
      logic [15:0]    byte_offset;
   } rsp_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_U     = 8'h55;

   localparam logic [3:0] METHOD_LEN_MAX  = 4'd8;
   localparam logic [3:0] METHOD_TEXT_MAX = 4'd7;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c inside {[8'h09:8'h0D]});
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_method_letter(input logic [7:0] c);
      return c inside {[CHAR_A:CHAR_U]};
   endfunction

   // letters, digits and / . ? & #
   function automatic logic is_uri_char(input logic [7:0] c);
      return is_alnum(c) || (c inside {8'h2F, 8'h2E, 8'h3F, 8'h26, 8'h23});
   endfunction

   // RFC token characters
   function automatic logic is_key_char(input logic [7:0] c);
      return is_alnum(c) ||
             (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                        8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
   endfunction

   function automatic logic is_value_char(input logic [7:0] c);
      return (c == 8'h09) || ((c >= 8'h20) && (c != 8'h7F));
   endfunction

   // Expected byte for each step of the "TTP/1.1" CR LF tail.
   function automatic logic [7:0] version_char(input state_type st);
      logic [7:0] ch;
      case (st)
         ST_VER_T1:    ch = CHAR_T;
         ST_VER_T2:    ch = CHAR_T;
         ST_VER_P:     ch = CHAR_P;
         ST_VER_SLASH: ch = CHAR_SLASH;
         ST_VER_MAJOR: ch = CHAR_ONE;
         ST_VER_DOT:   ch = CHAR_DOT;
         ST_VER_MINOR: ch = CHAR_ONE;
         ST_VER_CR:    ch = CHAR_CR;
         ST_VER_LF:    ch = CHAR_LF;
         default:      ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic method_type match_method(input logic [55:0] text,
                                                input logic [3:0]  len);
      method_type m;
      m = METHOD_NONE;
      case (len)
         4'd3: begin
            if (text == 56'h474554) m = METHOD_GET;
            else if (text == 56'h505554) m = METHOD_PUT;
         end
         4'd4: begin
            if (text == 56'h504F5354) m = METHOD_POST;
            else if (text == 56'h48454144) m = METHOD_HEAD;
         end
         4'd5: begin
            if (text == 56'h5452414345) m = METHOD_TRACE;
         end
         4'd6: begin
            if (text == 56'h44454C455445) m = METHOD_DELETE;
         end
         4'd7: begin
            if (text == 56'h4F5054494F4E53) m = METHOD_OPTIONS;
            else if (text == 56'h434F4E4E454354) m = METHOD_CONNECT;
         end
         default: m = METHOD_NONE;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ src/hrp_req_if.sv @@
// Request byte channel: valid/ready handshake carrying one stream byte per transaction.
`default_nettype none

interface hrp_req_if import hrp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/hrp_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one parse result per transaction.
`default_nettype none

interface hrp_rsp_if import hrp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/http_request_head_parser.sv @@
// Top level of the HTTP/1.1 request head parser: byte-wise state machine with registered ends.
`default_nettype none

// Channel   | Dir | Payload                                            | Transaction
// ----------+-----+----------------------------------------------------+----------------------
// req_chan  | in  | data_byte, start_of_request                        | valid & ready
// rsp_chan  | out | status, token_kind, token_start, token_length,     | valid & ready
//           |     | method_code, byte_offset                           |
//
// One byte per clock sustained while rsp_chan takes results; each result passes through
// the input register, then the parse step into the result register.
// The parse step is a single pass of character-class checks and one state update.
// reset is synchronous and clears both stage valids and all parse state.
// A stall on rsp_chan holds the result register; the input register takes one more byte
// only if it is empty; while it holds a byte, req_chan.ready is low until the result is taken.

module http_request_head_parser import hrp_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   hrp_req_if.sink    req_chan,
   hrp_rsp_if.source  rsp_chan
);

   // input register
   logic    in_valid_ff;
   req_type in_data_ff;

   // result register
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type out_data_in;

   // parse state
   state_type   state_ff,       state_in;
   logic [55:0] method_text_ff, method_text_in;
   logic [3:0]  method_len_ff,  method_len_in;
   offset_type  offset_ff,      offset_in;
   logic [15:0] tok_start_ff,   tok_start_in;
   method_type  method_ff,      method_in;

   logic advance;
   logic req_ready;

   // the parse step fires when a byte sits in the input register and the result slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_ready = !in_valid_ff || advance;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   // ---------------------------------------------------------------------
   // Parse step
   // ---------------------------------------------------------------------
   always_comb begin
      logic [7:0]     c;
      state_type      st;
      offset_type     off;
      token_kind_type kind;
      logic [15:0]    tstart;
      logic [15:0]    tlen;
      logic [55:0]    mtext;
      logic [3:0]     mlen;
      logic [15:0]    cts;
      method_type     dm;
      status_type     status;

      c = in_data_ff.data_byte;

      // start flag restarts the request before this byte is looked at
      if (in_data_ff.start_of_request) begin
         st    = ST_LINE_START;
         mtext = '0;
         mlen  = '0;
         off   = '0;
         cts   = '0;
         dm    = METHOD_NONE;
      end else begin
         st    = state_ff;
         mtext = method_text_ff;
         mlen  = method_len_ff;
         off   = offset_ff;
         cts   = tok_start_ff;
         dm    = method_ff;
      end

      kind      = TOKEN_NONE;
      tstart    = '0;
      tlen      = '0;
      offset_in = off;

      // error and complete are sticky; the offset freezes with them
      if ((st != ST_ERR) && (st != ST_DONE)) begin
         if (off >= OFFSET_LIMIT) begin
            st = ST_ERR;
         end else begin
            case (st)
               ST_LINE_START: begin
                  if (!is_ws(c)) begin
                     cts = off[15:0];
                     if (is_method_letter(c)) begin
                        if (mlen < METHOD_TEXT_MAX) mtext = {mtext[47:0], c};
                        if (mlen < METHOD_LEN_MAX) mlen = mlen + 4'd1;
                        st = ST_METHOD;
                     end else begin
                        st = ST_ERR;
                     end
                  end
               end
               ST_METHOD: begin
                  if (is_method_letter(c)) begin
                     if (mlen < METHOD_TEXT_MAX) mtext = {mtext[47:0], c};
                     if (mlen < METHOD_LEN_MAX) mlen = mlen + 4'd1;
                  end else if (c == CHAR_SPACE) begin
                     dm = match_method(mtext, mlen);
                     if (dm == METHOD_NONE) begin
                        st = ST_ERR;
                     end else begin
                        kind   = TOKEN_METHOD;
                        tstart = cts;
                        tlen   = off[15:0] - cts;
                        st     = ST_URI_START;
                     end
                  end else begin
                     st = ST_ERR;
                  end
               end
               ST_URI_START: begin
                  if (!is_ws(c)) begin
                     if (is_uri_char(c)) begin
                        cts = off[15:0];
                        st  = ST_URI;
                     end else begin
                        st = ST_ERR;
                     end
                  end
               end
               ST_URI: begin
                  if (!is_uri_char(c)) begin
                     if (c == CHAR_SPACE) begin
                        kind   = TOKEN_URI;
                        tstart = cts;
                        tlen   = off[15:0] - cts;
                        st     = ST_VER_START;
                     end else begin
                        st = ST_ERR;
                     end
                  end
               end
               ST_VER_START: begin
                  if (!is_ws(c)) st = (c == CHAR_H) ? ST_VER_T1 : ST_ERR;
               end
               ST_VER_T1, ST_VER_T2, ST_VER_P, ST_VER_SLASH, ST_VER_MAJOR,
               ST_VER_DOT, ST_VER_MINOR, ST_VER_CR, ST_VER_LF: begin
                  if (c != version_char(st)) st = ST_ERR;
                  else if (st == ST_VER_LF) st = ST_LINE_HEAD;
                  else st = state_type'(st + 5'd1);
               end
               ST_LINE_HEAD: begin
                  if (c == CHAR_CR) begin
                     st = ST_FINAL_LF;
                  end else if (is_key_char(c)) begin
                     cts = off[15:0];
                     st  = ST_KEY;
                  end else begin
                     st = ST_ERR;
                  end
               end
               ST_KEY: begin
                  if (!is_key_char(c)) begin
                     if (c == CHAR_COLON) begin
                        kind   = TOKEN_KEY;
                        tstart = cts;
                        tlen   = off[15:0] - cts;
                        st     = ST_SPACE;
                     end else begin
                        st = ST_ERR;
                     end
                  end
               end
               ST_SPACE: begin
                  if (c == CHAR_SPACE) begin
                     cts = off[15:0] + 16'd1;
                     st  = ST_VALUE;
                  end else begin
                     st = ST_ERR;
                  end
               end
               ST_VALUE: begin
                  if (!is_value_char(c)) begin
                     if (c == CHAR_CR) begin
                        kind   = TOKEN_VALUE;
                        tstart = cts;
                        tlen   = off[15:0] - cts;
                        st     = ST_VALUE_LF;
                     end else begin
                        st = ST_ERR;
                     end
                  end
               end
               ST_VALUE_LF: st = (c == CHAR_LF) ? ST_LINE_HEAD : ST_ERR;
               ST_FINAL_LF: st = (c == CHAR_LF) ? ST_DONE : ST_ERR;
               default:     st = ST_ERR;
            endcase
            offset_in = off + 17'd1;
         end
      end

      // no token is reported alongside an error
      if (st == ST_ERR) begin
         kind   = TOKEN_NONE;
         tstart = '0;
         tlen   = '0;
      end

      if (st == ST_ERR) status = STATUS_ERROR;
      else if (st == ST_DONE) status = STATUS_COMPLETE;
      else status = STATUS_BUSY;

      state_in       = st;
      method_text_in = mtext;
      method_len_in  = mlen;
      tok_start_in   = cts;
      method_in      = dm;

      out_data_in.status       = status;
      out_data_in.token_kind   = kind;
      out_data_in.token_start  = tstart;
      out_data_in.token_length = tlen;
      out_data_in.method_code  = dm;
      out_data_in.byte_offset  = off[15:0];
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= ST_LINE_START;
         method_text_ff <= '0;
         method_len_ff  <= '0;
         offset_ff      <= '0;
         tok_start_ff   <= '0;
         method_ff      <= METHOD_NONE;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff   <= 1'b1;
            state_ff       <= state_in;
            method_text_ff <= method_text_in;
            method_len_ff  <= method_len_in;
            offset_ff      <= offset_in;
            tok_start_ff   <= tok_start_in;
            method_ff      <= method_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         in_data_ff <= req_chan.data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/hrp_check_pkg.sv @@
// Byte classes and the result tracker for the HTTP request head parser testbench.
`timescale 1ns / 1ps

package hrp_check_pkg;
   import hrp_pkg::*;

   function automatic bit ws_byte(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit alnum_byte(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit method_letter(input logic [7:0] c);
      return c >= "A" && c <= "U";
   endfunction

   function automatic bit uri_byte(input logic [7:0] c);
      return alnum_byte(c) || c == "/" || c == "." || c == "?" || c == "&" || c == "#";
   endfunction

   // token characters of the header grammar
   function automatic bit key_byte(input logic [7:0] c);
      case (c)
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
         8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
         default: return alnum_byte(c);
      endcase
   endfunction

   function automatic bit value_byte(input logic [7:0] c);
      return c == 8'h09 || (c >= 8'h20 && c != 8'h7F);
   endfunction

   class head_parser_tracker;
      state_type   phase;
      logic [55:0] letters;
      logic [3:0]  letter_count;
      offset_type  byte_count;
      offset_type  token_begin;
      method_type  method_seen;
      rsp_type     pending_parses[$];
      int          mismatch_count;

      function new();
         restart();
         mismatch_count = 0;
      endfunction

      function void restart();
         phase        = ST_LINE_START;
         letters      = '0;
         letter_count = '0;
         byte_count   = '0;
         token_begin  = '0;
         method_seen  = METHOD_NONE;
      endfunction

      function void add_letter(input logic [7:0] c);
         if (letter_count < 4'd7) letters = {letters[47:0], c};
         if (letter_count < 4'd8) letter_count++;
      endfunction

      function method_type decode_method();
         method_type m;
         m = METHOD_NONE;
         case (letter_count)
            4'd3: begin
               if (letters == "GET") m = METHOD_GET;
               else if (letters == "PUT") m = METHOD_PUT;
            end
            4'd4: begin
               if (letters == "POST") m = METHOD_POST;
               else if (letters == "HEAD") m = METHOD_HEAD;
            end
            4'd5: if (letters == "TRACE") m = METHOD_TRACE;
            4'd6: if (letters == "DELETE") m = METHOD_DELETE;
            4'd7: begin
               if (letters == "OPTIONS") m = METHOD_OPTIONS;
               else if (letters == "CONNECT") m = METHOD_CONNECT;
            end
            default: m = METHOD_NONE;
         endcase
         return m;
      endfunction

      function logic [7:0] version_expect(input state_type s);
         case (s)
            ST_VER_T1, ST_VER_T2:       return "T";
            ST_VER_P:                   return "P";
            ST_VER_SLASH:               return "/";
            ST_VER_MAJOR, ST_VER_MINOR: return "1";
            ST_VER_DOT:                 return ".";
            ST_VER_CR:                  return CHAR_CR;
            ST_VER_LF:                  return CHAR_LF;
            default:                    return 8'h00;
         endcase
      endfunction

      // Works out the result of one accepted byte and queues it.
      function void note_byte(input req_type req);
         logic [7:0]     c;
         state_type      s;
         offset_type     here;
         token_kind_type kind;
         rsp_type        r;
         c = req.data_byte;
         if (req.start_of_request) restart();
         here = byte_count;
         s    = phase;
         kind = TOKEN_NONE;
         r    = '0;
         if (s != ST_ERR && s != ST_DONE) begin
            if (here >= OFFSET_LIMIT) begin
               s = ST_ERR;
            end else begin
               case (s)
                  ST_LINE_START: begin
                     if (!ws_byte(c)) begin
                        token_begin = here;
                        if (method_letter(c)) begin
                           add_letter(c);
                           s = ST_METHOD;
                        end else begin
                           s = ST_ERR;
                        end
                     end
                  end
                  ST_METHOD: begin
                     if (method_letter(c)) begin
                        add_letter(c);
                     end else if (c == CHAR_SPACE) begin
                        method_seen = decode_method();
                        if (method_seen == METHOD_NONE) begin
                           s = ST_ERR;
                        end else begin
                           kind = TOKEN_METHOD;
                           s    = ST_URI_START;
                        end
                     end else begin
                        s = ST_ERR;
                     end
                  end
                  ST_URI_START: begin
                     if (uri_byte(c)) begin
                        token_begin = here;
                        s = ST_URI;
                     end else if (!ws_byte(c)) begin
                        s = ST_ERR;
                     end
                  end
                  ST_URI: begin
                     if (c == CHAR_SPACE) begin
                        kind = TOKEN_URI;
                        s    = ST_VER_START;
                     end else if (!uri_byte(c)) begin
                        s = ST_ERR;
                     end
                  end
                  ST_VER_START: begin
                     if (!ws_byte(c)) s = (c == CHAR_H) ? ST_VER_T1 : ST_ERR;
                  end
                  ST_VER_T1, ST_VER_T2, ST_VER_P, ST_VER_SLASH, ST_VER_MAJOR,
                  ST_VER_DOT, ST_VER_MINOR, ST_VER_CR, ST_VER_LF: begin
                     if (c != version_expect(s)) s = ST_ERR;
                     else if (s == ST_VER_LF) s = ST_LINE_HEAD;
                     else s = state_type'(5'(s + 5'd1));
                  end
                  ST_LINE_HEAD: begin
                     if (c == CHAR_CR) begin
                        s = ST_FINAL_LF;
                     end else if (key_byte(c)) begin
                        token_begin = here;
                        s = ST_KEY;
                     end else begin
                        s = ST_ERR;
                     end
                  end
                  ST_KEY: begin
                     if (c == CHAR_COLON) begin
                        kind = TOKEN_KEY;
                        s    = ST_SPACE;
                     end else if (!key_byte(c)) begin
                        s = ST_ERR;
                     end
                  end
                  ST_SPACE: begin
                     if (c == CHAR_SPACE) begin
                        token_begin = here + 1'b1;
                        s = ST_VALUE;
                     end else begin
                        s = ST_ERR;
                     end
                  end
                  ST_VALUE: begin
                     if (c == CHAR_CR) begin
                        kind = TOKEN_VALUE;
                        s    = ST_VALUE_LF;
                     end else if (!value_byte(c)) begin
                        s = ST_ERR;
                     end
                  end
                  ST_VALUE_LF: s = (c == CHAR_LF) ? ST_LINE_HEAD : ST_ERR;
                  ST_FINAL_LF: s = (c == CHAR_LF) ? ST_DONE : ST_ERR;
                  default:     s = ST_ERR;
               endcase
               byte_count = here + 1'b1;
            end
         end
         if (s == ST_ERR) kind = TOKEN_NONE;
         if (kind != TOKEN_NONE) begin
            r.token_start  = token_begin[15:0];
            r.token_length = 16'(here - token_begin);
         end
         phase = s;
         r.token_kind  = kind;
         r.status      = (s == ST_ERR) ? STATUS_ERROR :
                         (s == ST_DONE) ? STATUS_COMPLETE : STATUS_BUSY;
         r.method_code = method_seen;
         r.byte_offset = here[15:0];
         pending_parses.push_back(r);
      endfunction

      task report(input string what);
         mismatch_count++;
         if (mismatch_count <= 40) $display("ERROR %0t: %s", $time, what);
      endtask

      task compare_field(input string name, input logic [15:0] got, input logic [15:0] want,
                         input logic [15:0] at);
         if (got !== want)
            report($sformatf("%s at byte %0d: got %0h, expected %0h", name, at, got, want));
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (pending_parses.size() == 0) begin
            report($sformatf("result %0h with nothing expected", got));
            return;
         end
         want = pending_parses.pop_front();
         compare_field("status", 16'(got.status), 16'(want.status), want.byte_offset);
         compare_field("token_kind", 16'(got.token_kind), 16'(want.token_kind),
                       want.byte_offset);
         compare_field("token_start", got.token_start, want.token_start, want.byte_offset);
         compare_field("token_length", got.token_length, want.token_length, want.byte_offset);
         compare_field("method_code", 16'(got.method_code), 16'(want.method_code),
                       want.byte_offset);
         compare_field("byte_offset", got.byte_offset, want.byte_offset, want.byte_offset);
      endtask
   endclass

endpackage

@@ verif/tb.sv @@
// Top-level testbench for http_request_head_parser: byte stimulus, result checking, watchdog.
`timescale 1ns / 1ps

module tb;
   import hrp_pkg::*;
   import hrp_check_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 8;
   localparam int STALL_LIMIT  = 200;   // cycles with no transaction on either channel
   localparam int RANDOM_BYTES = 1500;
   localparam int DRAIN_CYCLES = 8;     // two-stage pipeline, with margin

   typedef enum {
      CLASS_WS,
      CLASS_LETTER,
      CLASS_URI,
      CLASS_KEY,
      CLASS_VALUE
   } byte_class_type;

   logic clock;
   logic reset;
   bit   idling = 1'b1;      // random gaps on both channels while set
   int   quiet_cycles = 0;
   int   bytes_sent = 0;
   logic [7:0] stream[$];    // bytes of the sequence being built
   string method_names[8] = '{"GET", "PUT", "POST", "HEAD",
                              "TRACE", "DELETE", "OPTIONS", "CONNECT"};
   head_parser_tracker head_check;

   hrp_req_if req_if ();
   hrp_rsp_if rsp_if ();

   http_request_head_parser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Sequence building
   // ---------------------------------------------------------------------------

   // Draws random bytes until one falls into the wanted class.
   function automatic logic [7:0] pick(input byte_class_type cls);
      logic [7:0] c;
      bit         ok;
      do begin
         c = 8'($urandom_range(0, 255));
         case (cls)
            CLASS_WS:     ok = ws_byte(c);
            CLASS_LETTER: ok = method_letter(c);
            CLASS_URI:    ok = uri_byte(c);
            CLASS_KEY:    ok = key_byte(c);
            default:      ok = value_byte(c);
         endcase
      end while (!ok);
      return c;
   endfunction

   function void add_text(input string s);
      for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
   endfunction

   function void add_crlf();
      stream.push_back(CHAR_CR);
      stream.push_back(CHAR_LF);
   endfunction

   // Well-formed head with random content. A non-zero long_value gives a single
   // header whose value is that many bytes long.
   function void add_request(input int long_value);
      int headers;
      repeat ($urandom_range(0, 2)) stream.push_back(pick(CLASS_WS));
      // now and then a made-up method, mostly unknown or too long
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 9)) stream.push_back(pick(CLASS_LETTER));
      else
         add_text(method_names[$urandom_range(0, 7)]);
      stream.push_back(CHAR_SPACE);
      repeat ($urandom_range(0, 1)) stream.push_back(pick(CLASS_WS));
      repeat ($urandom_range(1, 12)) stream.push_back(pick(CLASS_URI));
      stream.push_back(CHAR_SPACE);
      repeat ($urandom_range(0, 1)) stream.push_back(pick(CLASS_WS));
      add_text("HTTP/1.1");
      add_crlf();
      headers = (long_value > 0) ? 1 : $urandom_range(0, 4);
      repeat (headers) begin
         repeat ($urandom_range(1, 8)) stream.push_back(pick(CLASS_KEY));
         stream.push_back(CHAR_COLON);
         stream.push_back(CHAR_SPACE);
         repeat ((long_value > 0) ? long_value : $urandom_range(0, 12))
            stream.push_back(pick(CLASS_VALUE));
         add_crlf();
      end
      add_crlf();
      // bytes after completion are ignored by the parser
      repeat ($urandom_range(0, 2)) stream.push_back(8'($urandom_range(0, 255)));
   endfunction

   // ---------------------------------------------------------------------------
   // Driving: inputs change on the falling edge, handshakes sampled on the rising
   // ---------------------------------------------------------------------------

   // Called just after a falling edge; returns just after a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic restart_head);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid                 = 1'b1;
      req_if.data.data_byte        = b;
      req_if.data.start_of_request = restart_head;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Sends the built sequence; the first byte optionally restarts the parser.
   task automatic send_stream(input bit fresh);
      for (int i = 0; i < stream.size(); i++) send_byte(stream[i], fresh && i == 0);
      stream.delete();
   endtask

   // Result side: ready drops in short random bursts while idling is on.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (idling && $urandom_range(0, 7) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // Monitoring: every accepted transaction is noted or checked at the rising edge
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) head_check.note_byte(req_if.data);
         if (rsp_if.valid && rsp_if.ready) head_check.check_result(rsp_if.data);
      end
   end

   // Watchdog: a long stretch without any transaction means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < STALL_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("FAIL http_request_head_parser");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   initial begin
      int random_start;
      int roll;
      head_check = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed heads.
      // No headers at all, then a byte after completion.
      add_text("GET / HTTP/1.1");
      add_crlf();
      add_crlf();
      stream.push_back(8'hFF);
      send_stream(1'b1);
      // Leading whitespace, a query URI and one header line.
      stream.push_back(8'h20);
      stream.push_back(8'h09);
      add_text("OPTIONS /a?b#c HTTP/1.1");
      add_crlf();
      add_text("Host: x");
      add_crlf();
      add_crlf();
      send_stream(1'b1);
      // Method too long, error holds for the next byte.
      add_text("CONNECTS G");
      send_stream(1'b1);
      // Unknown method.
      add_text("PATCH /");
      send_stream(1'b1);
      // Header line that starts with a colon.
      add_text("HEAD / HTTP/1.1");
      add_crlf();
      stream.push_back(CHAR_COLON);
      send_stream(1'b1);
      // Wrong version digit.
      add_text("DELETE / HTTP/1.0");
      send_stream(1'b1);
      // Zero byte at line start.
      stream.push_back(8'h00);
      send_stream(1'b1);

      // Random part: mostly well-formed heads, some corrupted or cut short,
      // some plain noise that may or may not restart the parser.
      random_start = bytes_sent;
      while (bytes_sent < random_start + RANDOM_BYTES) begin
         if (bytes_sent > random_start + RANDOM_BYTES * 85 / 100) idling = 1'b0;
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            repeat ($urandom_range(1, 8)) stream.push_back(8'($urandom_range(0, 255)));
            send_stream(1'($urandom_range(0, 1)));
         end else begin
            add_request(0);
            if (roll < 30)
               stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom_range(0, 255));
            else if (roll < 36)
               stream = stream[0:$urandom_range(0, stream.size() - 1)];
            send_stream(1'b1);
         end
      end
      req_if.valid = 1'b0;

      // Drain: every result in, then a few more cycles for anything stray.
      while (head_check.pending_parses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (head_check.mismatch_count == 0) begin
         $display("PASS http_request_head_parser");
      end else begin
         $display("FAIL http_request_head_parser");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/hrp_pkg.sv
src/hrp_req_if.sv
src/hrp_rsp_if.sv
src/http_request_head_parser.sv
verif/hrp_check_pkg.sv
verif/tb.sv
